// ===== sv/tdpt_pkg.sv =====
// Shared types and constants for the trial-division prime test core.
// No dependencies; imported by tdpt_div, trial_division_prime_test_core and the test bench.
package tdpt_pkg;

	localparam int unsigned NUMBER_WIDTH_DEF = 32;
	localparam int unsigned FIRST_DIVISOR    = 2;

	typedef enum logic [1:0] {
		TDPT_IDLE,
		TDPT_ISSUE,
		TDPT_WAIT,
		TDPT_EMIT
	} tdpt_state_t;

endpackage

// ===== sv/tdpt_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, quotient and remainder.
// Depends on tdpt_pkg for the default width.
module tdpt_div import tdpt_pkg::*; #(
	parameter int unsigned W = NUMBER_WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int unsigned CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dsr_q;

	logic [W:0]    trial;
	logic [W:0]    diff;
	logic          fits;

	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		diff  = trial - {1'b0, dsr_q};
		fits  = (trial >= {1'b0, dsr_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			// shift one dividend bit in, subtract when the divisor fits
			rem_q <= fits ? diff[W-1:0] : trial[W-1:0];
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== sv/trial_division_prime_test_core.sv =====
// Trial-division prime test: one number in, one is_prime flag out.
// Numbers below two go straight to the verdict; otherwise each trial divisor takes one pass
// through the divider (ISSUE, then WAIT for done), up to about 2^(W/2) divisors.
// Throughput: one number at a time; in_stall stays high until the verdict is queued.
// Reset: arst_n asynchronously clears the sequencer and the output valid; no memories.
// Depends on tdpt_pkg and tdpt_div.
module trial_division_prime_test_core import tdpt_pkg::*; #(
	parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [NUMBER_WIDTH-1:0] number_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    is_prime
);

	localparam int unsigned W = NUMBER_WIDTH;

	tdpt_state_t  state_q, state_d;
	logic [W-1:0] num_q;
	logic [W-1:0] d_q;
	logic         res_q;
	logic         out_valid_q;
	logic         is_prime_q;

	logic         in_accept;
	logic         slot_free;
	logic         div_start;
	logic         div_done;
	logic [W-1:0] div_quo;
	logic [W-1:0] div_rem;
	logic         below_two;
	logic         past_root;
	logic         divides;

	tdpt_div #(.W(W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (num_q),
		.divisor   (d_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	assign below_two = (number_value < W'(FIRST_DIVISOR));
	assign past_root = (d_q > div_quo);
	assign divides   = (div_rem == '0);
	assign slot_free = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			TDPT_IDLE: begin
				if (in_valid) state_d = below_two ? TDPT_EMIT : TDPT_ISSUE;
			end
			TDPT_ISSUE: state_d = TDPT_WAIT;
			TDPT_WAIT: begin
				if (div_done) state_d = (past_root || divides) ? TDPT_EMIT : TDPT_ISSUE;
			end
			TDPT_EMIT: begin
				if (slot_free) state_d = TDPT_IDLE;
			end
			default: state_d = TDPT_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = 1'b1;
		div_start = 1'b0;
		case (state_q)
			TDPT_IDLE:  in_stall  = 1'b0;
			TDPT_ISSUE: div_start = 1'b1;
			default: begin
				in_stall  = 1'b1;
				div_start = 1'b0;
			end
		endcase
	end

	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TDPT_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == TDPT_EMIT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			num_q <= number_value;
			d_q   <= W'(FIRST_DIVISOR);
			res_q <= 1'b0;
		end else if (state_q == TDPT_WAIT && div_done) begin
			// divisor past the square root means no factor exists
			res_q <= past_root;
			if (!past_root && !divides) d_q <= d_q + W'(1);
		end
		if (state_q == TDPT_EMIT && slot_free) is_prime_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign is_prime  = is_prime_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == TDPT_WAIT)
		else $error("divider finished outside the wait state");

	a_divisor_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == TDPT_WAIT || state_q == TDPT_ISSUE) |-> d_q >= W'(FIRST_DIVISOR))
		else $error("trial divisor below two");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q != TDPT_IDLE)
		else $error("sequencer stayed idle after taking a beat");

endmodule

// ===== test/trial_division_prime_test_core_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the trial-division prime test core: watches both channels,
// predicts each verdict and compares it with the result beat. Depends on tdpt_pkg.
module trial_division_prime_test_core_checker import tdpt_pkg::*; #(
	parameter int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic [NUMBER_WIDTH-1:0] number_value,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic                    is_prime,
	output int                      fail_count,
	output int                      pending,
	output int                      tested_count,
	output int                      prime_count
);

	typedef struct {
		logic [NUMBER_WIDTH-1:0] number;
		logic                    prime;
	} verdict_t;

	verdict_t verdict_q[$];

	// Try every divisor from two upward while d <= n / d.
	function automatic logic prime_flag(input logic [NUMBER_WIDTH-1:0] n);
		longint unsigned value;
		longint unsigned d;
		value = 64'(n);
		if (value < 2)
			return 1'b0;
		for (d = 64'(FIRST_DIVISOR); d <= value / d; d++)
			if (value % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	initial begin
		fail_count   = 0;
		pending      = 0;
		tested_count = 0;
		prime_count  = 0;
	end

	always @(posedge clk) begin
		verdict_t want;
		verdict_t got;
		if (arst_n) begin
			// Retire the result beat first so an early beat cannot match a fresh number.
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result beat is_prime=%0b", $time, is_prime);
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					if (is_prime !== want.prime) begin
						$display("%0t: is_prime mismatch for %0d: expected %0b, actual %0b",
							$time, want.number, want.prime, is_prime);
						fail_count++;
					end
					if (is_prime === 1'b1)
						prime_count++;
				end
			end
			if (in_valid && !in_stall) begin
				got.number = number_value;
				got.prime  = prime_flag(number_value);
				verdict_q.push_back(got);
				tested_count++;
			end
			pending = verdict_q.size();
		end
	end

endmodule

// ===== test/trial_division_prime_test_core_test.sv =====
`timescale 1ns / 1ps
// Top of the prime test core bench: clock, reset, number stimulus and result stalls.
// Depends on tdpt_pkg, trial_division_prime_test_core and its checker module.
module trial_division_prime_test_core_test;
	import tdpt_pkg::*;

	localparam int unsigned NUMBER_WIDTH = NUMBER_WIDTH_DEF;
	localparam int          RANDOM_COUNT = 80;
	localparam int          IDLE_LIMIT   = 1000000;
	localparam int          DRAIN_CYCLES = 64;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    in_valid     = 1'b0;
	logic [NUMBER_WIDTH-1:0] number_value = '0;
	logic                    out_stall    = 1'b0;
	logic                    in_stall;
	logic                    out_valid;
	logic                    is_prime;
	logic                    calm         = 1'b0;
	int                      fail_count;
	int                      pending;
	int                      tested_count;
	int                      prime_count;
	int                      idle_cycles  = 0;

	always #5 clk = ~clk;

	trial_division_prime_test_core #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.number_value (number_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_prime     (is_prime)
	);

	trial_division_prime_test_core_checker #(.NUMBER_WIDTH(NUMBER_WIDTH)) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.number_value (number_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.is_prime     (is_prime),
		.fail_count   (fail_count),
		.pending      (pending),
		.tested_count (tested_count),
		.prime_count  (prime_count)
	);

	// Stall the result side at random, except during the calm stretch.
	always @(negedge clk)
		out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 34);

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Present one number and hold it until the core takes the beat.
	task automatic send_number(input logic [NUMBER_WIDTH-1:0] v);
		@(negedge clk);
		if (!calm) begin
			while ($urandom_range(0, 99) < 34) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid     <= 1'b1;
		number_value <= v;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	function automatic logic [NUMBER_WIDTH-1:0] random_number();
		logic [NUMBER_WIDTH-1:0] v;
		int                      pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			v = NUMBER_WIDTH'($urandom_range(0, 300));
		end else if (pick < 70) begin
			v = NUMBER_WIDTH'($urandom_range(0, 65535));
		end else if (pick < 90) begin
			// Full-width values with a small factor finish after a few divisors.
			v = NUMBER_WIDTH'($urandom());
			if (v[NUMBER_WIDTH-1])
				v = v - (v % 3);
			else
				v[0] = 1'b0;
		end else begin
			v = NUMBER_WIDTH'($urandom_range(0, (1 << 22) - 1));
		end
		return v;
	endfunction

	logic [NUMBER_WIDTH-1:0] directed[$] = '{
		0, 1, 2, 3, 4, 5, 9, 25, 49, 97, 63001, 65521, 65535,
		32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h8000_0001,
		32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFF0, 16777213, 16744463
	};

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_number(directed[i]);

		for (int i = 0; i < RANDOM_COUNT; i++) begin
			calm = (i >= 40) && (i < 65);
			send_number(random_number());
		end
		calm = 1'b0;

		@(negedge clk);
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Tested %0d numbers (directed edge values and random mix), %0d reported prime.",
			tested_count, prime_count);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches, %0d verdicts outstanding", fail_count, pending);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
